// ----- hdl/csx_pkg.sv -----
package csx_pkg;

    localparam int DEF_MAX_FUNCS   = 256;
    localparam int DEF_STACK_DEPTH = 64;
    localparam int DEF_TIME_BITS   = 32;

    localparam logic [8:0] NUM_FUNCS_RESET = 9'd256;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_END   = 2'd1,
        OP_READ  = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    // control half of one command from front to back
    typedef struct packed {
        logic       do_add;
        logic       report_ok;
        status_t    status;
        logic [7:0] rid;
    } ctl_t;

endpackage

// ----- hdl/csx_ram.sv -----
module csx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/csx_cmdq.sv -----
module csx_cmdq #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + CW'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("command queue overflow");

endmodule

// ----- hdl/csx_front.sv -----
module csx_front #(
    parameter int MAX_FUNCS   = csx_pkg::DEF_MAX_FUNCS,
    parameter int STACK_DEPTH = csx_pkg::DEF_STACK_DEPTH,
    parameter int TIME_BITS   = csx_pkg::DEF_TIME_BITS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [1:0]           s_tuser,
    input  logic [39:0]          s_tdata,
    input  logic                 cfg_wr_en,
    input  logic [8:0]           cfg_wr_data,
    input  logic                 clr_busy,
    output logic                 cmd_valid,
    input  logic                 cmd_ready,
    output csx_pkg::ctl_t        cmd_ctl,
    output logic [TIME_BITS:0]   cmd_delta
);

    localparam int CW  = $clog2(STACK_DEPTH + 1);
    localparam int SAW = $clog2(STACK_DEPTH);

    typedef enum logic {F_IDLE, F_EXEC} fstate_t;

    fstate_t              state_reg;
    logic [1:0]           op_reg;
    logic [7:0]           id_reg;
    logic [TIME_BITS-1:0] t_reg, mark_reg, mark_next;
    logic [CW-1:0]        count_reg, count_next, count_dec;
    logic [8:0]           nf_reg;
    logic [7:0]           top;
    logic                 stk_we;
    logic [TIME_BITS-1:0] diff;
    logic                 t_ge;
    logic                 fire;

    function automatic logic id_in_range(logic [7:0] id, logic [8:0] nf);
        return ({1'b0, id} < nf) && (32'(id) < MAX_FUNCS);
    endfunction

    assign count_dec = count_reg - CW'(1);
    assign s_tready  = (state_reg == F_IDLE) && !clr_busy;
    assign diff      = t_reg - mark_reg;
    assign t_ge      = (t_reg >= mark_reg);
    assign fire      = (state_reg == F_EXEC) && cmd_ready;
    assign cmd_valid = (state_reg == F_EXEC);

    csx_ram #(.WIDTH(8), .DEPTH(STACK_DEPTH)) u_stack (
        .aclk  (aclk),
        .we    (stk_we && fire),
        .waddr (count_reg[SAW-1:0]),
        .wdata (id_reg),
        .raddr (count_dec[SAW-1:0]),
        .rdata (top)
    );

    always_comb begin
        cmd_ctl.do_add = 1'b0;
        cmd_ctl.status = csx_pkg::ST_OK;
        cmd_ctl.rid    = id_reg;
        cmd_delta      = '0;
        stk_we         = 1'b0;
        count_next     = count_reg;
        mark_next      = mark_reg;
        case (csx_pkg::op_t'(op_reg))
            csx_pkg::OP_START: begin
                if (!id_in_range(id_reg, nf_reg)) begin
                    cmd_ctl.status = csx_pkg::ST_RANGE;
                end else if (count_reg == CW'(STACK_DEPTH)) begin
                    cmd_ctl.status = csx_pkg::ST_FULL;
                end else begin
                    if (count_reg != '0) begin
                        cmd_ctl.do_add = 1'b1;
                        cmd_ctl.rid    = top;
                        cmd_delta      = t_ge ? {1'b0, diff} : '0;
                    end
                    stk_we     = 1'b1;
                    count_next = count_reg + CW'(1);
                    mark_next  = t_reg;
                end
            end
            csx_pkg::OP_END: begin
                if (count_reg == '0) begin
                    cmd_ctl.status = csx_pkg::ST_EMPTY;
                end else begin
                    cmd_ctl.do_add = 1'b1;
                    cmd_ctl.rid    = top;
                    cmd_delta      = t_ge ? ({1'b0, diff} + (TIME_BITS+1)'(1)) : '0;
                    count_next     = count_dec;
                    mark_next      = (t_reg == '1) ? t_reg : t_reg + TIME_BITS'(1);
                end
            end
            default: begin
                if (!id_in_range(id_reg, nf_reg)) begin
                    cmd_ctl.status = csx_pkg::ST_RANGE;
                end
            end
        endcase
        cmd_ctl.report_ok = id_in_range(cmd_ctl.rid, nf_reg);
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            op_reg <= s_tuser;
            id_reg <= s_tdata[7:0];
            t_reg  <= TIME_BITS'(s_tdata[39:8]);
        end
        if (!aresetn) begin
            state_reg <= F_IDLE;
            count_reg <= '0;
            mark_reg  <= '0;
            nf_reg    <= csx_pkg::NUM_FUNCS_RESET;
        end else begin
            if (cfg_wr_en) begin
                nf_reg <= cfg_wr_data;
            end
            case (state_reg)
                F_IDLE: begin
                    if (s_tvalid && s_tready) begin
                        state_reg <= F_EXEC;
                    end
                end
                F_EXEC: begin
                    if (fire) begin
                        count_reg <= count_next;
                        mark_reg  <= mark_next;
                        state_reg <= F_IDLE;
                    end
                end
                default: state_reg <= F_IDLE;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready && cmd_valid)
        else $error("item taken while another is in work");

endmodule

// ----- hdl/csx_back.sv -----
module csx_back #(
    parameter int MAX_FUNCS = csx_pkg::DEF_MAX_FUNCS,
    parameter int TIME_BITS = csx_pkg::DEF_TIME_BITS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cmd_valid,
    output logic                 cmd_ready,
    input  csx_pkg::ctl_t        cmd_ctl,
    input  logic [TIME_BITS:0]   cmd_delta,
    output logic                 clr_busy,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [39:0]          m_tdata,
    output logic [1:0]           m_tuser
);

    localparam int AAW = $clog2(MAX_FUNCS);
    localparam int WB  = (TIME_BITS > 32) ? TIME_BITS : 32;

    typedef enum logic [1:0] {B_CLEAR, B_IDLE, B_UPDATE} bstate_t;

    bstate_t              state_reg;
    logic [AAW-1:0]       clr_cnt_reg;
    csx_pkg::ctl_t        ctl_reg;
    logic [TIME_BITS:0]   delta_reg;
    logic                 m_valid_reg;
    logic [7:0]           m_id_reg;
    logic [31:0]          m_total_reg, total_next;
    csx_pkg::status_t     m_status_reg;

    logic [TIME_BITS-1:0] acc, acc_new, acc_wdata;
    logic [TIME_BITS:0]   sum;
    logic [WB-1:0]        acc_wide;
    logic [AAW-1:0]       raddr, waddr;
    logic                 acc_we, fire;

    assign clr_busy  = (state_reg == B_CLEAR);
    assign cmd_ready = (state_reg == B_IDLE);
    assign fire      = (state_reg == B_UPDATE) && (!m_valid_reg || m_tready);
    assign raddr     = (state_reg == B_IDLE) ? AAW'(cmd_ctl.rid) : AAW'(ctl_reg.rid);
    assign waddr     = clr_busy ? clr_cnt_reg : AAW'(ctl_reg.rid);

    assign sum       = {1'b0, acc} + delta_reg;
    assign acc_new   = !ctl_reg.do_add ? acc : (sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0]);
    assign acc_we    = clr_busy || (fire && ctl_reg.do_add);
    assign acc_wdata = clr_busy ? '0 : acc_new;
    assign acc_wide  = WB'(acc_new);

    always_comb begin
        if (!ctl_reg.report_ok) begin
            total_next = '0;
        end else if (acc_wide > WB'(32'hFFFF_FFFF)) begin
            total_next = '1;
        end else begin
            total_next = acc_wide[31:0];
        end
    end

    csx_ram #(.WIDTH(TIME_BITS), .DEPTH(MAX_FUNCS)) u_acc (
        .aclk  (aclk),
        .we    (acc_we),
        .waddr (waddr),
        .wdata (acc_wdata),
        .raddr (raddr),
        .rdata (acc)
    );

    always_ff @(posedge aclk) begin
        if (cmd_valid && cmd_ready) begin
            ctl_reg   <= cmd_ctl;
            delta_reg <= cmd_delta;
        end
        if (fire) begin
            m_id_reg     <= ctl_reg.rid;
            m_total_reg  <= total_next;
            m_status_reg <= ctl_reg.status;
        end
        if (!aresetn) begin
            state_reg   <= B_CLEAR;
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                B_CLEAR: begin
                    clr_cnt_reg <= clr_cnt_reg + AAW'(1);
                    if (clr_cnt_reg == AAW'(MAX_FUNCS - 1)) begin
                        state_reg <= B_IDLE;
                    end
                end
                B_IDLE: begin
                    if (cmd_valid) begin
                        state_reg <= B_UPDATE;
                    end
                end
                B_UPDATE: begin
                    if (fire) begin
                        state_reg <= B_IDLE;
                    end
                end
                default: state_reg <= B_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_total_reg, m_id_reg};
    assign m_tuser  = m_status_reg;

    a_quiet_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_busy |-> !m_valid_reg && !cmd_ready)
        else $error("activity during clearing pass");

    a_write_on_update: assert property (@(posedge aclk) disable iff (!aresetn)
        acc_we && !clr_busy |-> state_reg == B_UPDATE && ctl_reg.do_add)
        else $error("stray accumulator write");

endmodule

// ----- hdl/call_stack_exclusive_time_core.sv -----
// channel  | dir | tdata (low bit up)              | tuser
// s_       | in  | func_id[7:0], timestamp[39:8]   | op[1:0]
// m_       | out | result_id[7:0], total_time[39:8]| status[1:0]
// cfg_     | in  | cfg_wr_data = num_functions     | -
//
// Input: the front takes one item at a time; it reads the stack RAM top, then updates.
// Back: one item at a time, accumulator RAM read then saturating write and output register load.
// After reset, s_tready stays low while the accumulators are zeroed.
// A 2-entry command queue sits between front and back; m_tready low fills it, then s_tready drops.
module call_stack_exclusive_time_core #(
    parameter int MAX_FUNCS   = csx_pkg::DEF_MAX_FUNCS,
    parameter int STACK_DEPTH = csx_pkg::DEF_STACK_DEPTH,
    parameter int TIME_BITS   = csx_pkg::DEF_TIME_BITS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,     // func_id, timestamp
    input  logic [1:0]  s_tuser,     // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,     // result_id, total_time
    output logic [1:0]  m_tuser,     // status
    input  logic        cfg_wr_en,
    input  logic [8:0]  cfg_wr_data
);

    localparam int CTLW = $bits(csx_pkg::ctl_t);
    localparam int QW   = CTLW + TIME_BITS + 1;

    logic               clr_busy;
    logic               f_valid, f_ready, b_valid, b_ready;
    csx_pkg::ctl_t      f_ctl, b_ctl;
    logic [TIME_BITS:0] f_delta, b_delta;
    logic [QW-1:0]      q_out;

    csx_front #(
        .MAX_FUNCS   (MAX_FUNCS),
        .STACK_DEPTH (STACK_DEPTH),
        .TIME_BITS   (TIME_BITS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tuser     (s_tuser),
        .s_tdata     (s_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .clr_busy    (clr_busy),
        .cmd_valid   (f_valid),
        .cmd_ready   (f_ready),
        .cmd_ctl     (f_ctl),
        .cmd_delta   (f_delta)
    );

    csx_cmdq #(.WIDTH(QW), .DEPTH(2)) u_q (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  ({f_delta, f_ctl}),
        .pop_valid  (b_valid),
        .pop_ready  (b_ready),
        .pop_data   (q_out)
    );

    assign b_ctl   = q_out[CTLW-1:0];
    assign b_delta = q_out[QW-1:CTLW];

    csx_back #(
        .MAX_FUNCS (MAX_FUNCS),
        .TIME_BITS (TIME_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (b_valid),
        .cmd_ready (b_ready),
        .cmd_ctl   (b_ctl),
        .cmd_delta (b_delta),
        .clr_busy  (clr_busy),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule
